/* src/sts_pkg.sv */
// ----------------------------------------------------------------------------
// Sphere triangle subdivider package
// Widths, vertex type, controller command/status words and the emit order.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int TEX_WIDTH   = 17;
   localparam int INDEX_WIDTH = 20;
   localparam int RAD_WIDTH   = COORD_WIDTH - 1;
   localparam int SUM_WIDTH   = COORD_WIDTH + 1;
   localparam int SQ_WIDTH    = 2 * SUM_WIDTH;
   localparam int ROOT_WIDTH  = SUM_WIDTH;
   localparam int REM_WIDTH   = ROOT_WIDTH + 3;
   localparam int DVD_WIDTH   = SUM_WIDTH + RAD_WIDTH;
   localparam int QUO_WIDTH   = DVD_WIDTH - COORD_WIDTH;
   localparam int VERTS_PER_TRI = 12;
   localparam int CNT_WIDTH   = 5;
   localparam int CSR_ADDR_WIDTH = 2;
   localparam logic [RAD_WIDTH-1:0] RADIUS_RESET = RAD_WIDTH'(65536);
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_RADIUS = '0;

   // vertex sources
   localparam logic [2:0] SRC_C0  = 3'd0;
   localparam logic [2:0] SRC_C1  = 3'd1;
   localparam logic [2:0] SRC_C2  = 3'd2;
   localparam logic [2:0] SRC_M01 = 3'd3;
   localparam logic [2:0] SRC_M12 = 3'd4;
   localparam logic [2:0] SRC_M02 = 3'd5;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
      logic [COORD_WIDTH-1:0] z;
      logic [TEX_WIDTH-1:0]   u;
      logic [TEX_WIDTH-1:0]   v;
   } vert_type;

   typedef struct packed {
      logic       in_ready;
      logic [1:0] slot;
      logic       mid_load;
      logic [1:0] mid_sel;
      logic       sq_step;
      logic       sq_first;
      logic       sqrt_step;
      logic       div_mul;
      logic       div_load;
      logic       div_step;
      logic       div_store;
      logic [1:0] comp;
      logic       emit_load;
      logic [3:0] emit_k;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic in_accept;
      logic out_free;
   } stat_type;

   function automatic logic [2:0] vert_src(input logic [3:0] k);
      logic [2:0] s;
      case (k)
         4'd0:    s = SRC_C0;
         4'd1:    s = SRC_M01;
         4'd2:    s = SRC_M02;
         4'd3:    s = SRC_M01;
         4'd4:    s = SRC_C1;
         4'd5:    s = SRC_M12;
         4'd6:    s = SRC_M01;
         4'd7:    s = SRC_M12;
         4'd8:    s = SRC_M02;
         4'd9:    s = SRC_M02;
         4'd10:   s = SRC_M12;
         default: s = SRC_C2;
      endcase
      return s;
   endfunction

endpackage

/* src/sts_if.sv */
// ----------------------------------------------------------------------------
// Sphere triangle subdivider channels
// Corner word channel and vertex word channel, valid/ready.
// ----------------------------------------------------------------------------
interface sts_req_if import sts_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] pos_z;
   logic [TEX_WIDTH-1:0]          tex_u;
   logic [TEX_WIDTH-1:0]          tex_v;
   logic                          new_pass;
   modport source(output valid, pos_x, pos_y, pos_z, tex_u, tex_v, new_pass, input ready);
   modport sink(input valid, pos_x, pos_y, pos_z, tex_u, tex_v, new_pass, output ready);
endinterface

interface sts_rsp_if import sts_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] out_x;
   logic signed [COORD_WIDTH-1:0] out_y;
   logic signed [COORD_WIDTH-1:0] out_z;
   logic [TEX_WIDTH-1:0]          out_u;
   logic [TEX_WIDTH-1:0]          out_v;
   logic [INDEX_WIDTH-1:0]        vertex_number;
   logic                          last_of_triangle;
   modport source(output valid, out_x, out_y, out_z, out_u, out_v, vertex_number,
                  last_of_triangle, input ready);
   modport sink(input valid, out_x, out_y, out_z, out_u, out_v, vertex_number,
                last_of_triangle, output ready);
endinterface

/* src/sts_ctrl.sv */
// ----------------------------------------------------------------------------
// Sphere triangle subdivider controller
// Sequences corner capture, midpoint normalisation and vertex emission.
// ----------------------------------------------------------------------------
module sts_ctrl import sts_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LOAD   = 4'd1;
   localparam logic [3:0] S_SQ     = 4'd2;
   localparam logic [3:0] S_SQRT   = 4'd3;
   localparam logic [3:0] S_DMUL   = 4'd4;
   localparam logic [3:0] S_DLOAD  = 4'd5;
   localparam logic [3:0] S_DIV    = 4'd6;
   localparam logic [3:0] S_DSTORE = 4'd7;
   localparam logic [3:0] S_EMIT   = 4'd8;

   localparam logic [CNT_WIDTH-1:0] SQ_LAST   = CNT_WIDTH'(3);
   localparam logic [CNT_WIDTH-1:0] SQRT_LAST = CNT_WIDTH'(ROOT_WIDTH - 1);
   localparam logic [CNT_WIDTH-1:0] DIV_LAST  = CNT_WIDTH'(QUO_WIDTH - 1);
   localparam logic [3:0] EMIT_LAST = 4'(VERTS_PER_TRI - 1);

   logic [3:0]           state_ff, state_in;
   logic [1:0]           held_ff, held_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [1:0]           comp_ff, comp_in;
   logic [1:0]           mid_ff, mid_in;
   logic [3:0]           k_ff, k_in;

   always_comb begin
      state_in = state_ff;
      held_in  = held_ff;
      cnt_in   = cnt_ff;
      comp_in  = comp_ff;
      mid_in   = mid_ff;
      k_in     = k_ff;
      cmd           = '0;
      cmd.slot      = held_ff;
      cmd.mid_sel   = mid_ff;
      cmd.comp      = comp_ff;
      cmd.emit_k    = k_ff;
      cmd.emit_last = (k_ff == EMIT_LAST);
      unique case (state_ff)
         S_IDLE: begin
            cmd.in_ready = 1'b1;
            if (stat.in_accept) begin
               if (held_ff == 2'd2) begin
                  held_in  = 2'd0;
                  mid_in   = 2'd0;
                  state_in = S_LOAD;
               end else begin
                  held_in = held_ff + 2'd1;
               end
            end
         end
         S_LOAD: begin
            cmd.mid_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_SQ;
         end
         S_SQ: begin
            cmd.sq_step  = 1'b1;
            cmd.sq_first = (cnt_ff == '0);
            cmd.comp     = cnt_ff[1:0];
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == SQ_LAST) begin
               cnt_in   = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               comp_in  = 2'd0;
               state_in = S_DMUL;
            end
         end
         S_DMUL: begin
            cmd.div_mul = 1'b1;
            state_in    = S_DLOAD;
         end
         S_DLOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_DSTORE;
         end
         S_DSTORE: begin
            cmd.div_store = 1'b1;
            if (comp_ff == 2'd2) begin
               if (mid_ff == 2'd2) begin
                  k_in     = '0;
                  state_in = S_EMIT;
               end else begin
                  mid_in   = mid_ff + 2'd1;
                  state_in = S_LOAD;
               end
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = S_DMUL;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_load = 1'b1;
               k_in          = k_ff + 4'd1;
               if (k_ff == EMIT_LAST) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         held_ff  <= '0;
         cnt_ff   <= '0;
         comp_ff  <= '0;
         mid_ff   <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         cnt_ff   <= cnt_in;
         comp_ff  <= comp_in;
         mid_ff   <= mid_in;
         k_ff     <= k_in;
      end
   end

`ifndef ASSERT_OFF
   a_third_corner: assert property (@(posedge clock) disable iff (reset)
      (stat.in_accept && held_ff == 2'd2) |=> (state_ff == S_LOAD && held_ff == 2'd0))
      else $error("third corner did not start subdivision");
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (k_ff <= EMIT_LAST))
      else $error("emit count out of range");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> stat.out_free)
      else $error("vertex loaded over a waiting word");
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_ff != 2'd3)
      else $error("corner count overflow");
`endif

endmodule

/* src/sts_dp.sv */
// ----------------------------------------------------------------------------
// Sphere triangle subdivider datapath
// Corner store, squared-length accumulate, bitwise root, restoring divide.
// ----------------------------------------------------------------------------
module sts_dp import sts_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [RAD_WIDTH-1:0] radius,
   input  cmd_type              cmd,
   output stat_type             stat,
   sts_req_if.sink              req,
   sts_rsp_if.source            rsp
);

   vert_type corner_ff [3];
   vert_type mid_ff [3];
   logic [SUM_WIDTH-1:0]  mag_ff [3];
   logic [SUM_WIDTH-1:0]  mag_in [3];
   logic                  neg_ff [3];
   logic [SQ_WIDTH-1:0]   prod_ff, acc_ff;
   logic [REM_WIDTH-1:0]  srem_ff;
   logic [ROOT_WIDTH-1:0] root_ff;
   logic [DVD_WIDTH-1:0]  dvd_ff;
   logic [ROOT_WIDTH-1:0] drem_ff;
   logic [QUO_WIDTH-1:0]  quo_ff;
   logic [INDEX_WIDTH-1:0] idx_ff;
   logic                  out_valid_ff;
   vert_type              out_vert_ff;
   logic [INDEX_WIDTH-1:0] out_num_ff;
   logic                  out_last_ff;

   vert_type va, vb, vsel;
   logic [SUM_WIDTH-1:0]   sum [3];
   logic [1:0]             sq_idx;
   logic [REM_WIDTH-1:0]   srem_sh, strial;
   logic [ROOT_WIDTH:0]    dtrial;
   logic [COORD_WIDTH-1:0] qval, store_val;
   logic [TEX_WIDTH:0]     u_sum, v_sum;
   logic [2:0]             src;

   assign req.ready      = cmd.in_ready;
   assign stat.in_accept = req.valid & cmd.in_ready;
   assign stat.out_free  = ~out_valid_ff | rsp.ready;

   always_comb begin
      va = (cmd.mid_sel == 2'd1) ? corner_ff[1] : corner_ff[0];
      vb = (cmd.mid_sel == 2'd0) ? corner_ff[1] : corner_ff[2];
      sum[0] = SUM_WIDTH'($signed(va.x)) + SUM_WIDTH'($signed(vb.x));
      sum[1] = SUM_WIDTH'($signed(va.y)) + SUM_WIDTH'($signed(vb.y));
      sum[2] = SUM_WIDTH'($signed(va.z)) + SUM_WIDTH'($signed(vb.z));
      for (int i = 0; i < 3; i++)
         mag_in[i] = sum[i][SUM_WIDTH-1] ? (~sum[i] + 1'b1) : sum[i];
      u_sum = {1'b0, va.u} + {1'b0, vb.u};
      v_sum = {1'b0, va.v} + {1'b0, vb.v};
      sq_idx = (cmd.comp == 2'd3) ? 2'd2 : cmd.comp;
      srem_sh = {srem_ff[REM_WIDTH-3:0], acc_ff[SQ_WIDTH-1:SQ_WIDTH-2]};
      strial  = REM_WIDTH'({root_ff, 2'b01});
      dtrial  = {drem_ff, dvd_ff[QUO_WIDTH-1]};
      qval    = quo_ff;
      if (root_ff == '0)
         store_val = '0;
      else if (neg_ff[cmd.comp == 2'd3 ? 2'd2 : cmd.comp])
         store_val = ~qval + 1'b1;
      else
         store_val = qval;
      src = vert_src(cmd.emit_k);
      case (src)
         SRC_C0:  vsel = corner_ff[0];
         SRC_C1:  vsel = corner_ff[1];
         SRC_C2:  vsel = corner_ff[2];
         SRC_M01: vsel = mid_ff[0];
         SRC_M12: vsel = mid_ff[1];
         default: vsel = mid_ff[2];
      endcase
   end

   always_ff @(posedge clock) begin
      if (stat.in_accept) begin
         corner_ff[cmd.slot].x <= req.pos_x;
         corner_ff[cmd.slot].y <= req.pos_y;
         corner_ff[cmd.slot].z <= req.pos_z;
         corner_ff[cmd.slot].u <= req.tex_u;
         corner_ff[cmd.slot].v <= req.tex_v;
      end
      if (cmd.mid_load) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= mag_in[i];
            neg_ff[i] <= sum[i][SUM_WIDTH-1];
         end
         mid_ff[cmd.mid_sel].u <= u_sum[TEX_WIDTH:1];
         mid_ff[cmd.mid_sel].v <= v_sum[TEX_WIDTH:1];
         srem_ff <= '0;
         root_ff <= '0;
      end
      if (cmd.sq_step) begin
         prod_ff <= mag_ff[sq_idx] * mag_ff[sq_idx];
         acc_ff  <= cmd.sq_first ? '0 : acc_ff + prod_ff;
      end
      if (cmd.sqrt_step) begin
         acc_ff <= {acc_ff[SQ_WIDTH-3:0], 2'b00};
         if (srem_sh >= strial) begin
            srem_ff <= srem_sh - strial;
            root_ff <= {root_ff[ROOT_WIDTH-2:0], 1'b1};
         end else begin
            srem_ff <= srem_sh;
            root_ff <= {root_ff[ROOT_WIDTH-2:0], 1'b0};
         end
      end
      if (cmd.div_mul)
         dvd_ff <= mag_ff[sq_idx] * DVD_WIDTH'(radius);
      if (cmd.div_load)
         drem_ff <= ROOT_WIDTH'(dvd_ff[DVD_WIDTH-1:QUO_WIDTH]);
      if (cmd.div_step) begin
         dvd_ff[QUO_WIDTH-1:0] <= {dvd_ff[QUO_WIDTH-2:0], 1'b0};
         if (dtrial >= {1'b0, root_ff}) begin
            drem_ff <= ROOT_WIDTH'(dtrial - {1'b0, root_ff});
            quo_ff  <= {quo_ff[QUO_WIDTH-2:0], 1'b1};
         end else begin
            drem_ff <= dtrial[ROOT_WIDTH-1:0];
            quo_ff  <= {quo_ff[QUO_WIDTH-2:0], 1'b0};
         end
      end
      if (cmd.div_store) begin
         case (cmd.comp)
            2'd0:    mid_ff[cmd.mid_sel].x <= store_val;
            2'd1:    mid_ff[cmd.mid_sel].y <= store_val;
            default: mid_ff[cmd.mid_sel].z <= store_val;
         endcase
      end
      if (cmd.emit_load) begin
         out_vert_ff <= vsel;
         out_num_ff  <= idx_ff;
         out_last_ff <= cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (stat.in_accept && req.new_pass)
            idx_ff <= '0;
         else if (cmd.emit_load)
            idx_ff <= idx_ff + 1'b1;
         if (cmd.emit_load)
            out_valid_ff <= 1'b1;
         else if (rsp.ready)
            out_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.out_x            = $signed(out_vert_ff.x);
   assign rsp.out_y            = $signed(out_vert_ff.y);
   assign rsp.out_z            = $signed(out_vert_ff.z);
   assign rsp.out_u            = out_vert_ff.u;
   assign rsp.out_v            = out_vert_ff.v;
   assign rsp.vertex_number    = out_num_ff;
   assign rsp.last_of_triangle = out_last_ff;

endmodule

/* src/sphere_triangle_subdivider_unit.sv */
// Corner words are taken only while the controller is idle, so corners of the next
// triangle wait until the last vertex word of this one is loaded for output.
// Each of three midpoints takes a load, square and root steps, then per component a
// multiply, load, divide and store in the shared units; then 12 words go out.
// Reset: synchronous, clears the corner count, vertex index and output valid;
// the radius register returns to 1.0.
// ----------------------------------------------------------------------------
// Sphere triangle subdivider top level
// Register port, controller and datapath.
// ----------------------------------------------------------------------------
module sphere_triangle_subdivider_unit import sts_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   sts_req_if.sink                   req_chan,
   sts_rsp_if.source                 rsp_chan,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   logic [RAD_WIDTH-1:0] radius_ff;
   cmd_type  cmd;
   stat_type stat;

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_RADIUS) ? 32'(radius_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset)
         radius_ff <= RADIUS_RESET;
      else if (psel && penable && pwrite && pready && paddr == ADDR_RADIUS)
         radius_ff <= pwdata[RAD_WIDTH-1:0];
   end

   sts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   sts_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .radius (radius_ff),
      .cmd    (cmd),
      .stat   (stat),
      .req    (req_chan),
      .rsp    (rsp_chan)
   );

endmodule

/* sim/sts_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Subdivider vertex checker
// Watches the corner and vertex channels, predicts the twelve vertex words of
// every triangle and compares each vertex word field by field in order.
// ----------------------------------------------------------------------------
module sts_checker import sts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   sts_req_if.sink               req_mon,
   sts_rsp_if.sink               rsp_mon,
   input  logic                  radius_we,
   input  logic [RAD_WIDTH-1:0]  radius_wdata,
   output int                    fail_count,
   output int                    pending_count
);

   typedef struct {
      logic signed [COORD_WIDTH-1:0] x, y, z;
      logic [TEX_WIDTH-1:0]          u, v;
      logic [INDEX_WIDTH-1:0]        num;
      logic                          last;
   } vertex_word_type;

   vertex_word_type               vertex_q[$];
   logic [RAD_WIDTH-1:0]          radius;
   logic signed [COORD_WIDTH-1:0] cx[3], cy[3], cz[3];
   logic [TEX_WIDTH-1:0]          cu[3], cv[3];
   logic [1:0]                    held;
   logic [INDEX_WIDTH-1:0]        next_num;

   assign pending_count = vertex_q.size();

   function automatic logic [63:0] int_root(input logic [63:0] x);
      logic [63:0] r;
      r = 0;
      for (int b = 31; b >= 0; b--)
         if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x) r |= 64'd1 << b;
      return r;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] scale_component(
         input logic signed [COORD_WIDTH:0] s, input logic [63:0] n,
         input logic [RAD_WIDTH-1:0] rad);
      logic [63:0] m, q;
      longint      lim;
      m = (s < 0) ? 64'(-s) : 64'(s);
      lim = (64'sd1 << (COORD_WIDTH - 1)) - 1;
      if (n == 0) return '0;
      q = (m * 64'(rad)) / n;
      if (s < 0) return (q > 64'(lim) + 1) ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                          : COORD_WIDTH'(-longint'(q));
      return (q > 64'(lim)) ? COORD_WIDTH'(lim) : COORD_WIDTH'(q);
   endfunction

   function automatic vertex_word_type edge_midpoint(input int a, input int b);
      vertex_word_type w;
      logic signed [COORD_WIDTH:0] sx, sy, sz;
      logic [63:0] mx, my, mz, n;
      sx = cx[a] + cx[b];
      sy = cy[a] + cy[b];
      sz = cz[a] + cz[b];
      mx = (sx < 0) ? 64'(-sx) : 64'(sx);
      my = (sy < 0) ? 64'(-sy) : 64'(sy);
      mz = (sz < 0) ? 64'(-sz) : 64'(sz);
      n = int_root(mx * mx + my * my + mz * mz);
      w.x = scale_component(sx, n, radius);
      w.y = scale_component(sy, n, radius);
      w.z = scale_component(sz, n, radius);
      w.u = TEX_WIDTH'(({1'b0, cu[a]} + {1'b0, cu[b]}) >> 1);
      w.v = TEX_WIDTH'(({1'b0, cv[a]} + {1'b0, cv[b]}) >> 1);
      return w;
   endfunction

   task automatic predict_triangle();
      vertex_word_type p[6];
      vertex_word_type w;
      for (int k = 0; k < 3; k++) begin
         p[k].x = cx[k]; p[k].y = cy[k]; p[k].z = cz[k];
         p[k].u = cu[k]; p[k].v = cv[k];
      end
      p[3] = edge_midpoint(0, 1);
      p[4] = edge_midpoint(1, 2);
      p[5] = edge_midpoint(0, 2);
      for (int k = 0; k < VERTS_PER_TRI; k++) begin
         w = p[vert_src(4'(k))];
         w.num = next_num;
         w.last = (k == VERTS_PER_TRI - 1);
         vertex_q = {vertex_q, w};
         next_num = next_num + 1'b1;
      end
   endtask

   task automatic compare_vertex();
      vertex_word_type e;
      if (vertex_q.size() == 0) begin
         $error("vertex word with none expected");
         fail_count++;
         return;
      end
      e = vertex_q.pop_front();
      if (rsp_mon.out_x !== e.x) begin
         $error("out_x exp %0d got %0d", e.x, rsp_mon.out_x); fail_count++;
      end
      if (rsp_mon.out_y !== e.y) begin
         $error("out_y exp %0d got %0d", e.y, rsp_mon.out_y); fail_count++;
      end
      if (rsp_mon.out_z !== e.z) begin
         $error("out_z exp %0d got %0d", e.z, rsp_mon.out_z); fail_count++;
      end
      if (rsp_mon.out_u !== e.u) begin
         $error("out_u exp %0d got %0d", e.u, rsp_mon.out_u); fail_count++;
      end
      if (rsp_mon.out_v !== e.v) begin
         $error("out_v exp %0d got %0d", e.v, rsp_mon.out_v); fail_count++;
      end
      if (rsp_mon.vertex_number !== e.num) begin
         $error("vertex_number exp %0d got %0d", e.num, rsp_mon.vertex_number);
         fail_count++;
      end
      if (rsp_mon.last_of_triangle !== e.last) begin
         $error("last_of_triangle exp %0d got %0d", e.last, rsp_mon.last_of_triangle);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         radius <= RADIUS_RESET;
         held = 0;
         next_num = 0;
         fail_count = 0;
         vertex_q.delete();
      end else begin
         if (radius_we) radius <= radius_wdata;
         if (rsp_mon.valid && rsp_mon.ready) compare_vertex();
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.new_pass) next_num = 0;
            cx[held] = req_mon.pos_x; cy[held] = req_mon.pos_y; cz[held] = req_mon.pos_z;
            cu[held] = req_mon.tex_u; cv[held] = req_mon.tex_v;
            if (held == 2) begin
               held = 0;
               predict_triangle();
            end else
               held = held + 1'b1;
         end
      end
   end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Subdivider testbench
// Sends directed and random triangles through the subdivider under several
// radius settings, with random idling on both sides and one long receiver
// hold-off; the checker predicts and compares every vertex word.
// ----------------------------------------------------------------------------
module tb import sts_pkg::*; ();

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_TRIS = 48;

   logic clock = 0;
   logic reset = 1;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;
   int   fail_count, pending_count;
   int   cycles = 0;
   logic quiet = 0;
   logic hold_off = 0;
   logic hold_done = 0;
   logic radius_we;

   sts_req_if req_chan();
   sts_rsp_if rsp_chan();

   sphere_triangle_subdivider_unit u_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready));

   assign radius_we = psel && penable && pwrite && pready && paddr == ADDR_RADIUS;

   sts_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_chan.sink), .rsp_mon(rsp_chan.sink),
      .radius_we(radius_we), .radius_wdata(pwdata[RAD_WIDTH-1:0]),
      .fail_count(fail_count), .pending_count(pending_count));

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 0;
      req_chan.pos_x = 0; req_chan.pos_y = 0; req_chan.pos_z = 0;
      req_chan.tex_u = 0; req_chan.tex_v = 0; req_chan.new_pass = 0;
      rsp_chan.ready = 0;
   end

   // receiver: random stall bursts, a long hold-off on request
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off && !hold_done) begin
            rsp_chan.ready <= 0;
            repeat (3000) @(posedge clock);
            hold_done = 1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            rsp_chan.ready <= 0;
            repeat (gap - 1) @(posedge clock);
         end else
            rsp_chan.ready <= 1;
      end
   end

   task automatic csr_write(input logic [RAD_WIDTH-1:0] val);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_RADIUS; pwdata <= 32'(val);
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic send_corner(input logic signed [COORD_WIDTH-1:0] x, y, z,
                              input logic [TEX_WIDTH-1:0] u, v, input logic np);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.pos_x <= x; req_chan.pos_y <= y; req_chan.pos_z <= z;
      req_chan.tex_u <= u; req_chan.tex_v <= v; req_chan.new_pass <= np;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
      case ($urandom_range(0, 3))
         0:       return COORD_WIDTH'($urandom);
         1:       return COORD_WIDTH'($signed($urandom_range(0, 262143)) - 131072);
         2:       return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
         default: return COORD_WIDTH'($signed($urandom_range(0, 8191)) - 4096);
      endcase
   endfunction

   task automatic rand_triangle(input logic np);
      for (int k = 0; k < 3; k++)
         send_corner(rand_coord(), rand_coord(), rand_coord(),
                     TEX_WIDTH'($urandom), TEX_WIDTH'($urandom),
                     k == 0 ? np : ($urandom_range(0, 15) == 0));
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, zero-length sum, opposite corners, mid-triangle new pass
      send_corner(24'h7fffff, 24'h7fffff, 24'h7fffff, 17'h1ffff, 17'h1ffff, 1);
      send_corner(24'h7fffff, 24'h7fffff, 24'h7fffff, 17'h1ffff, 17'h1ffff, 0);
      send_corner(24'h800000, 24'h800000, 24'h800000, 17'h0, 17'h0, 0);
      send_corner(24'h010000, 24'h0, 24'h0, 17'h0, 17'h1ffff, 0);
      send_corner(-24'sh010000, 24'h0, 24'h0, 17'h1ffff, 17'h0, 1);
      send_corner(24'h0, 24'h0, 24'h0, 17'h10000, 17'h10001, 0);
      send_corner(24'h0, 24'h0, 24'h0, 17'h0, 17'h0, 0);
      send_corner(24'h000001, 24'hffffff, 24'h0, 17'h1, 17'h1, 0);
      send_corner(24'h800000, 24'h7fffff, 24'h000001, 17'h3, 17'h2, 0);
      drain();
      csr_write(23'h7fffff);
      send_corner(24'h000001, 24'h0, 24'h0, 17'h0, 17'h0, 0);
      send_corner(24'h000001, 24'h0, 24'h0, 17'h0, 17'h0, 0);
      send_corner(24'h800000, 24'h800000, 24'h0, 17'h0, 17'h0, 0);
      rand_triangle(0);
      drain();
      csr_write(23'h0);
      rand_triangle(1);
      rand_triangle(0);
      drain();
      csr_write(23'h028000);
      // long receiver hold-off while corners keep coming
      hold_off = 1;
      for (int t = 0; t < RANDOM_TRIS / 3; t++) rand_triangle($urandom_range(0, 7) == 0);
      drain();
      csr_write(23'($urandom));
      for (int t = 0; t < RANDOM_TRIS / 3; t++) rand_triangle($urandom_range(0, 7) == 0);
      drain();
      csr_write(RADIUS_RESET);
      quiet = 1;
      for (int t = 0; t < RANDOM_TRIS / 3; t++) rand_triangle($urandom_range(0, 7) == 0);
      drain();
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
